/* rtl/jh32_pkg.sv */
package jh32_pkg;

  localparam logic [31:0] GOLDEN_RATIO = 32'h9E37_79B9;
  localparam int unsigned BLOCK_BYTES  = 12;
  localparam logic [3:0]  LAST_SLOT    = 4'(BLOCK_BYTES - 1);
  localparam int unsigned MIX_STEPS    = 9;
  localparam logic [3:0]  LAST_STEP    = 4'(MIX_STEPS - 1);
  localparam int unsigned CMD_DEPTH    = 4;
  localparam int unsigned CMD_PTR_W    = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CNT_W    = $clog2(CMD_DEPTH + 1);

  // work handed from the byte packer to the mixer
  typedef struct packed {
    logic [31:0] wa;
    logic [31:0] wb;
    logic [31:0] wc;
    logic [31:0] len;
    logic        blk;
    logic        fin;
    logic        first;
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MIX,
    B_TAIL,
    B_OUT
  } back_state_t;

  typedef enum logic [1:0] {
    MIX_A,
    MIX_B,
    MIX_C
  } mix_tgt_t;

  function automatic logic [4:0] mix_shift(input logic [3:0] step);
    logic [4:0] sh;
    unique case (step)
      4'd0:    sh = 5'd13;
      4'd1:    sh = 5'd8;
      4'd2:    sh = 5'd13;
      4'd3:    sh = 5'd12;
      4'd4:    sh = 5'd16;
      4'd5:    sh = 5'd5;
      4'd6:    sh = 5'd3;
      4'd7:    sh = 5'd10;
      4'd8:    sh = 5'd15;
      default: sh = 5'd0;
    endcase
    return sh;
  endfunction

  function automatic mix_tgt_t mix_target(input logic [3:0] step);
    mix_tgt_t t;
    unique case (step)
      4'd0, 4'd3, 4'd6: t = MIX_A;
      4'd1, 4'd4, 4'd7: t = MIX_B;
      default:          t = MIX_C;
    endcase
    return t;
  endfunction

endpackage

/* rtl/jh32_front.sv */
module jh32_front
  import jh32_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_data_byte,
  input  logic       in_byte_valid,
  input  logic       in_last,
  output logic       cmd_push,
  output cmd_t       cmd_data,
  input  logic       cmd_full
);

  logic [31:0] wa_r, wa_nxt;
  logic [31:0] wb_r, wb_nxt;
  logic [31:0] wc_r, wc_nxt;
  logic [31:0] len_r, len_nxt;
  logic [3:0]  slot_r, slot_nxt;
  logic        first_r, first_nxt;
  logic        accept;
  logic        blk_done;
  logic [31:0] wa_ins, wb_ins, wc_ins;
  logic [31:0] len_inc;

  assign in_full  = cmd_full;
  assign accept   = in_push && !cmd_full;
  assign blk_done = in_byte_valid && (slot_r == LAST_SLOT);
  assign len_inc  = len_r + 32'(in_byte_valid);

  always_comb begin
    wa_ins = wa_r;
    wb_ins = wb_r;
    wc_ins = wc_r;
    if (in_byte_valid) begin
      unique case (slot_r[3:2])
        2'd0:    wa_ins[8*slot_r[1:0] +: 8] = in_data_byte;
        2'd1:    wb_ins[8*slot_r[1:0] +: 8] = in_data_byte;
        default: wc_ins[8*slot_r[1:0] +: 8] = in_data_byte;
      endcase
    end
  end

  always_comb begin
    cmd_push       = accept && (blk_done || in_last);
    cmd_data.wa    = wa_ins;
    cmd_data.wb    = wb_ins;
    cmd_data.wc    = wc_ins;
    cmd_data.len   = len_inc;
    cmd_data.blk   = blk_done;
    cmd_data.fin   = in_last;
    cmd_data.first = first_r;
  end

  always_comb begin
    wa_nxt    = wa_r;
    wb_nxt    = wb_r;
    wc_nxt    = wc_r;
    len_nxt   = len_r;
    slot_nxt  = slot_r;
    first_nxt = first_r;
    if (accept && (in_byte_valid || in_last)) begin
      priority if (in_last) begin
        wa_nxt    = '0;
        wb_nxt    = '0;
        wc_nxt    = '0;
        len_nxt   = '0;
        slot_nxt  = '0;
        first_nxt = 1'b1;
      end else if (blk_done) begin
        wa_nxt    = '0;
        wb_nxt    = '0;
        wc_nxt    = '0;
        len_nxt   = len_inc;
        slot_nxt  = '0;
        first_nxt = 1'b0;
      end else begin
        wa_nxt   = wa_ins;
        wb_nxt   = wb_ins;
        wc_nxt   = wc_ins;
        len_nxt  = len_inc;
        slot_nxt = slot_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wa_r    <= '0;
      wb_r    <= '0;
      wc_r    <= '0;
      len_r   <= '0;
      slot_r  <= '0;
      first_r <= 1'b1;
    end else begin
      wa_r    <= wa_nxt;
      wb_r    <= wb_nxt;
      wc_r    <= wc_nxt;
      len_r   <= len_nxt;
      slot_r  <= slot_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

/* rtl/jh32_cmd_fifo.sv */
module jh32_cmd_fifo
  import jh32_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  cmd_t                 mem_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_r, wr_nxt;
  logic [CMD_PTR_W-1:0] rd_r, rd_nxt;
  logic [CMD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign full     = (cnt_r == CMD_CNT_W'(CMD_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_r];

  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + CMD_CNT_W'(do_push) - CMD_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/jh32_back.sv */
module jh32_back
  import jh32_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] init_value,
  input  cmd_t        cmd_data,
  input  logic        cmd_empty,
  output logic        cmd_pop,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_hash_value
);

  back_state_t state_r, state_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [31:0] a_r, a_nxt;
  logic [31:0] b_r, b_nxt;
  logic [31:0] c_r, c_nxt;
  logic [31:0] len_r, len_nxt;
  logic        fin_r, fin_nxt;
  logic        tail_r, tail_nxt;

  logic [31:0] base_a, base_b, base_c;
  logic [31:0] mix_a, mix_b, mix_c;
  logic [4:0]  sh;

  // two-word result buffer
  logic [31:0] obuf_r [2];
  logic        owr_r, ord_r;
  logic [1:0]  ocnt_r, ocnt_nxt;
  logic        obuf_full;
  logic        obuf_push;
  logic        obuf_pop;

  assign obuf_full      = (ocnt_r == 2'd2);
  assign out_empty      = (ocnt_r == 2'd0);
  assign obuf_pop       = out_pop && !out_empty;
  assign out_hash_value = obuf_r[ord_r];

  assign base_a = cmd_data.first ? GOLDEN_RATIO : a_r;
  assign base_b = cmd_data.first ? GOLDEN_RATIO : b_r;
  assign base_c = cmd_data.first ? init_value : c_r;

  assign sh    = mix_shift(step_r);
  assign mix_a = (c_r >> sh) ^ (a_r - b_r - c_r);
  assign mix_b = (a_r << sh) ^ (b_r - c_r - a_r);
  assign mix_c = (b_r >> sh) ^ (c_r - a_r - b_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!cmd_empty) begin
          state_nxt = B_MIX;
        end
      end
      B_MIX: begin
        if (step_r == LAST_STEP) begin
          priority if (!fin_r) begin
            state_nxt = B_IDLE;
          end else if (tail_r) begin
            state_nxt = B_TAIL;
          end else begin
            state_nxt = B_OUT;
          end
        end
      end
      B_TAIL: state_nxt = B_MIX;
      B_OUT: begin
        if (!obuf_full) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop   = 1'b0;
    obuf_push = 1'b0;
    step_nxt  = step_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    len_nxt   = len_r;
    fin_nxt   = fin_r;
    tail_nxt  = tail_r;
    unique case (state_r)
      B_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop  = 1'b1;
          step_nxt = '0;
          a_nxt    = base_a + cmd_data.wa;
          b_nxt    = base_b + cmd_data.wb;
          if (cmd_data.blk) begin
            c_nxt = base_c + cmd_data.wc;
          end else begin
            // low byte of c is kept for the length on the tail
            c_nxt = base_c + cmd_data.len + {cmd_data.wc[23:0], 8'h00};
          end
          len_nxt  = cmd_data.len;
          fin_nxt  = cmd_data.fin;
          tail_nxt = cmd_data.blk && cmd_data.fin;
        end
      end
      B_MIX: begin
        step_nxt = step_r + 4'd1;
        unique case (mix_target(step_r))
          MIX_A:   a_nxt = mix_a;
          MIX_B:   b_nxt = mix_b;
          default: c_nxt = mix_c;
        endcase
      end
      B_TAIL: begin
        step_nxt = '0;
        c_nxt    = c_r + len_r;
        tail_nxt = 1'b0;
      end
      B_OUT: begin
        obuf_push = !obuf_full;
      end
      default: ;
    endcase
  end

  always_comb begin
    ocnt_nxt = ocnt_r + 2'(obuf_push) - 2'(obuf_pop);
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    len_r <= len_nxt;
    if (obuf_push) begin
      obuf_r[owr_r] <= c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      step_r  <= '0;
      fin_r   <= 1'b0;
      tail_r  <= 1'b0;
      owr_r   <= 1'b0;
      ord_r   <= 1'b0;
      ocnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      fin_r   <= fin_nxt;
      tail_r  <= tail_nxt;
      owr_r   <= owr_r ^ obuf_push;
      ord_r   <= ord_r ^ obuf_pop;
      ocnt_r  <= ocnt_nxt;
    end
  end

endmodule

/* rtl/jenkins_hash_32_unit.sv */
// Streaming 32-bit lookup2 hash, one message byte per word.
//
// Input queue port: a word is taken when in_push is high and in_full low.
// in_byte_valid marks in_data_byte as part of the message, in_last ends the
// message and asks for one hash. A word with neither flag does nothing.
// Result queue port: while out_empty is low, out_hash_value holds the oldest
// hash; out_pop takes it. Config port: cfg_init_value is written when
// cfg_valid is high (cfg_ready is always high); write it only while idle.
//
// Throughput: one byte per cycle for long messages, while in_full stays low.
// The mixer takes one command per 12-byte block or message end, with a tail
// step and a second mix pass when the end falls on a block boundary; a
// 4-word command queue between packer and mixer absorbs that. A hash reaches
// the result queue after its last word passes the command queue and the mixer.
// A stalled receiver fills the 2-word result buffer, then the mixer, then
// the command queue, then raises in_full.
// Synchronous reset clears all control state and sets the seed to 0.
module jenkins_hash_32_unit
  import jh32_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_last,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_hash_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_init_value
);

  logic [31:0] init_r;
  logic        cmd_push;
  logic        cmd_full;
  logic        cmd_pop;
  logic        cmd_empty;
  cmd_t        cmd_in;
  cmd_t        cmd_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      init_r <= cfg_init_value;
    end
  end

  jh32_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_data_byte  (in_data_byte),
    .in_byte_valid (in_byte_valid),
    .in_last       (in_last),
    .cmd_push      (cmd_push),
    .cmd_data      (cmd_in),
    .cmd_full      (cmd_full)
  );

  jh32_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_out),
    .empty     (cmd_empty)
  );

  jh32_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .init_value     (init_r),
    .cmd_data       (cmd_out),
    .cmd_empty      (cmd_empty),
    .cmd_pop        (cmd_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_hash_value (out_hash_value)
  );

endmodule

/* rtl/jh32_checker.sv */
module jh32_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [31:0] out_hash_value,
  input logic        cfg_ready
);

  // nothing is left over from before reset
  a_empty_after_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> out_empty)
    else $error("result queue not empty after reset");

  a_open_after_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !in_full)
    else $error("input queue full after reset");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("config port not ready");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!out_empty && !out_pop) && $past(rst_n) |-> !out_empty && $stable(out_hash_value))
    else $error("waiting hash changed or vanished");

endmodule

bind jenkins_hash_32_unit jh32_checker u_jh32_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_full        (in_full),
  .out_empty      (out_empty),
  .out_pop        (out_pop),
  .out_hash_value (out_hash_value),
  .cfg_ready      (cfg_ready)
);

/* tb/sv/jenkins_hash_32_unit_test.sv */
module jenkins_hash_32_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import jh32_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 30;
  localparam int WORDS_PER_PHASE = 70;
  localparam int PHASES = 8;

  // lookup2 predictor plus the queue of hashes still owed by the block
  class lookup2_scoreboard;
    bit [31:0] seed_value;
    bit [31:0] acc_a;
    bit [31:0] acc_b;
    bit [31:0] acc_c;
    bit [31:0] lane_c;
    bit [31:0] msg_len;
    bit [3:0]  byte_slot;
    bit        active;
    bit [31:0] hash_queue[$];
    int        errors;
    int        messages;
    int        empty_messages;
    int        bytes_in;

    function void set_seed(bit [31:0] v);
      seed_value = v;
    endfunction

    function void restart();
      acc_a = GOLDEN_RATIO;
      acc_b = GOLDEN_RATIO;
      acc_c = seed_value;
      lane_c = 0;
      msg_len = 0;
      byte_slot = 0;
      active = 1'b0;
    endfunction

    function void lookup2_mix(inout bit [31:0] a, inout bit [31:0] b, inout bit [31:0] c);
      a = (c >> 13) ^ (a - b - c);
      b = (a << 8) ^ (b - c - a);
      c = (b >> 13) ^ (c - a - b);
      a = (c >> 12) ^ (a - b - c);
      b = (a << 16) ^ (b - c - a);
      c = (b >> 5) ^ (c - a - b);
      a = (c >> 3) ^ (a - b - c);
      b = (a << 10) ^ (b - c - a);
      c = (b >> 15) ^ (c - a - b);
    endfunction

    function void note_word(bit [7:0] data, bit valid, bit last_mark);
      bit [31:0] a;
      bit [31:0] b;
      bit [31:0] c;
      bit [31:0] lane_byte;
      if (!active) restart();
      if (valid) begin
        lane_byte = 32'(data) << {byte_slot[1:0], 3'b000};
        if (byte_slot < 4) acc_a += lane_byte;
        else if (byte_slot < 8) acc_b += lane_byte;
        else lane_c += lane_byte;
        msg_len++;
        bytes_in++;
        active = 1'b1;
        if (byte_slot == LAST_SLOT) begin
          acc_c += lane_c;
          lane_c = 0;
          lookup2_mix(acc_a, acc_b, acc_c);
          byte_slot = 0;
        end else begin
          byte_slot++;
        end
      end
      if (last_mark) begin
        a = acc_a;
        b = acc_b;
        c = acc_c + msg_len + (lane_c << 8);
        lookup2_mix(a, b, c);
        hash_queue.push_back(c);
        messages++;
        if (msg_len == 0) empty_messages++;
        restart();
      end
    endfunction

    function void check_hash(logic [31:0] actual);
      bit [31:0] want;
      if (hash_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected hash, expected none, actual %h", $time, actual);
      end else begin
        want = hash_queue.pop_front();
        if (actual !== want) begin
          errors++;
          $display("%0t: hash mismatch, expected %h, actual %h", $time, want, actual);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_byte_valid = 1'b0;
  logic        in_last = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [31:0] out_hash_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_init_value = 32'h0;

  lookup2_scoreboard sb;
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  bit quiet = 1'b0;
  int words_sent = 0;
  int seeds_used = 0;
  int cycle_count = 0;

  jenkins_hash_32_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_data_byte   (in_data_byte),
    .in_byte_valid  (in_byte_valid),
    .in_last        (in_last),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_hash_value (out_hash_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_init_value (cfg_init_value)
  );

  always #10 clk = ~clk;

  // receiver with random stall bursts
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) sb.check_hash(out_hash_value);
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(99) < stall_pct) begin
      out_pop <= 1'b0;
      stall_left <= $urandom_range(4, 0);
    end else begin
      out_pop <= 1'b1;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic push_word(bit [7:0] data, bit valid, bit last_mark);
    if (!quiet && $urandom_range(99) < gap_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data_byte <= data;
    in_byte_valid <= valid;
    in_last <= last_mark;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_word(data, valid, last_mark);
    if (valid || last_mark) words_sent++;
  endtask

  task automatic write_seed(bit [31:0] v);
    cfg_valid <= 1'b1;
    cfg_init_value <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_seed(v);
    seeds_used++;
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (sb.hash_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_message();
    int len;
    int r;
    bit end_on_byte;
    bit [7:0] data;
    r = $urandom_range(99);
    if (r < 6) len = 0;
    else if (r < 20) len = 12 * $urandom_range(6, 1);
    else if (r < 85) len = $urandom_range(30, 1);
    else len = $urandom_range(120, 31);
    end_on_byte = (len != 0) && ($urandom_range(1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 8) push_word(8'($urandom), 1'b0, 1'b0);
      if ($urandom_range(9) == 0) data = $urandom_range(1) ? 8'hFF : 8'h00;
      else data = 8'($urandom);
      push_word(data, 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte) push_word(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    bit [31:0] seed;
    int target;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words under the reset seed
    gap_pct = 20;
    stall_pct = 20;
    push_word(8'h3C, 1'b0, 1'b0);
    push_word(8'h00, 1'b0, 1'b1);
    push_word(8'hFF, 1'b1, 1'b1);
    push_word(8'h00, 1'b1, 1'b1);
    for (int i = 0; i < 12; i++) push_word(8'hFF, 1'b1, i == 11);
    push_word(8'h80, 1'b1, 1'b0);
    push_word(8'h01, 1'b1, 1'b0);
    push_word(8'h55, 1'b1, 1'b0);
    push_word(8'hAA, 1'b1, 1'b0);
    push_word(8'h00, 1'b0, 1'b1);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: seed = 32'h0000_0000;
        1: seed = 32'hFFFF_FFFF;
        2: seed = 32'h8000_0000;
        3: seed = 32'h0000_0001;
        default: seed = $urandom;
      endcase
      write_seed(seed);
      quiet = (phase == PHASES - 1);
      gap_pct = 20 * $urandom_range(2);
      stall_pct = 20 * $urandom_range(2);
      target = words_sent + WORDS_PER_PHASE;
      while (words_sent < target) send_message();
      drain();
    end

    $display("covered %0d messages (%0d empty, %0d bytes) over %0d seed settings",
             sb.messages, sb.empty_messages, sb.bytes_in, seeds_used);
    $display("with random sender gaps and receiver stalls, %0d mismatches", sb.errors);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/jh32_pkg.sv
rtl/jh32_front.sv
rtl/jh32_cmd_fifo.sv
rtl/jh32_back.sv
rtl/jenkins_hash_32_unit.sv
rtl/jh32_checker.sv
tb/sv/jenkins_hash_32_unit_test.sv
